// File: rtl/scope_frame_crc16_builder_top_assert.svh
// Assertion macros for the telemetry framer RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef SCOPE_FRAME_CRC16_BUILDER_TOP_ASSERT_SVH
`define SCOPE_FRAME_CRC16_BUILDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SFCB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");
// Next-cycle implication, disabled during reset.
`define SFCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define SFCB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SFCB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/sfcb_pkg.sv
// Package for the telemetry framer: frame constants, CRC-16/MODBUS byte update
// and the control struct between serializer and CRC unit. No dependencies.
`timescale 1ns / 1ps

package sfcb_pkg;

   localparam int IDX_W = 4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Byte positions within one frame.
   localparam logic [IDX_W-1:0] IDX_FIRST  = 4'd0;
   localparam logic [IDX_W-1:0] IDX_CRC_LO = 4'd8;
   localparam logic [IDX_W-1:0] IDX_CRC_HI = 4'd9;

   // Control from the serializer to the CRC accumulator.
   typedef struct packed {
      logic init;
      logic update;
   } crc_ctrl_type;

   // Folds one byte into the reflected CRC, one bit per step.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/sfcb_crc_unit.sv
// CRC-16/MODBUS accumulator: one data byte folded in per cycle while update is set.
// Depends on sfcb_pkg.
`timescale 1ns / 1ps

module sfcb_crc_unit
   import sfcb_pkg::*;
(
   input  logic         clock,
   input  crc_ctrl_type crc_ctrl,
   input  logic [7:0]   crc_byte,
   output logic [15:0]  crc_value
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   // Restart on a new item, fold in the current data byte on update, otherwise hold.
   always_comb begin
      crc_in = crc_ff;
      if (crc_ctrl.init) begin
         crc_in = CRC_INIT;
      end else if (crc_ctrl.update) begin
         crc_in = crc16_byte(crc_ff, crc_byte);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc_value = crc_ff;

endmodule

// File: rtl/sfcb_serializer.sv
// Frame serializer: holds the item's samples, steps through the ten frame
// bytes and drives the registered result ports. Depends on sfcb_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "scope_frame_crc16_builder_top_assert.svh"

module sfcb_serializer
   import sfcb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_chan0,
   input  logic signed [15:0] req_chan1,
   input  logic signed [15:0] req_chan2,
   input  logic signed [15:0] req_chan3,
   input  logic [15:0]        crc_value,
   output crc_ctrl_type       crc_ctrl,
   output logic [7:0]         crc_byte,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte
);

   logic [7:0][7:0]   bytes_ff;
   logic [7:0][7:0]   bytes_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;
   logic              active_ff;
   logic              active_in;
   logic              strobe_ff;
   logic              strobe_in;
   logic [7:0]        out_byte_ff;
   logic [7:0]        out_byte_in;
   logic              out_last_ff;
   logic              out_last_in;
   logic              accept;
   logic              on_data;
   logic [7:0]        cur_byte;

   // A new item may enter during the last byte of the current frame.
   assign busy   = active_ff && (idx_ff != IDX_CRC_HI);
   assign accept = start && !busy;

   // Pick the byte for this cycle: data, then CRC low, then CRC high.
   assign on_data = active_ff && (idx_ff < IDX_CRC_LO);
   always_comb begin
      case (idx_ff)
         IDX_CRC_LO: cur_byte = crc_value[7:0];
         IDX_CRC_HI: cur_byte = crc_value[15:8];
         default:    cur_byte = bytes_ff[idx_ff[2:0]];
      endcase
   end

   assign crc_byte        = bytes_ff[idx_ff[2:0]];
   assign crc_ctrl.init   = accept;
   assign crc_ctrl.update = on_data;

   // Sequencing of frame positions.
   always_comb begin
      bytes_in  = bytes_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      if (accept) begin
         bytes_in  = {req_chan3, req_chan2, req_chan1, req_chan0};
         idx_in    = IDX_FIRST;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (idx_ff == IDX_CRC_HI) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   // Result register.
   assign strobe_in   = active_ff;
   assign out_byte_in = cur_byte;
   assign out_last_in = active_ff && (idx_ff == IDX_CRC_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         strobe_ff   <= 1'b0;
         idx_ff      <= IDX_FIRST;
         out_last_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         strobe_ff   <= strobe_in;
         idx_ff      <= idx_in;
         out_last_ff <= out_last_in;
      end
      bytes_ff    <= bytes_in;
      out_byte_ff <= out_byte_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte  = out_last_ff;

   // A frame starts at its first byte right after acceptance.
   `SFCB_ASSERT_NEXT(a_start_frame, clock, reset, accept, active_ff && (idx_ff == IDX_FIRST))
   // Mid-frame the position advances by exactly one each cycle.
   `SFCB_ASSERT_NEXT(a_step, clock, reset, active_ff && (idx_ff != IDX_CRC_HI) && !accept,
      active_ff && (idx_ff == $past(idx_ff) + 4'd1))
   // The position never runs past the CRC high byte.
   `SFCB_ASSERT_IMPLY(a_idx_range, clock, reset, active_ff, idx_ff <= IDX_CRC_HI)
   // The last-byte flag only marks a strobed item.
   `SFCB_ASSERT_IMPLY(a_last_strobed, clock, reset, rsp_last_byte, rsp_strobe)

endmodule

// File: rtl/scope_frame_crc16_builder_top.sv
// Telemetry framer: four 16-bit samples in, ten-byte frame with CRC-16/MODBUS out.
// The first byte reaches the rsp_ ports through the sequencer state and then the result register.
// The result port carries one byte per cycle;
// the next item is taken while the last byte is loaded into the result register,
// so frames follow without a gap.
// The receiver cannot stall. Synchronous reset clears the sequencer, strobe and last-byte flag.
`timescale 1ns / 1ps

module scope_frame_crc16_builder_top
   import sfcb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_chan0,
   input  logic signed [15:0] req_chan1,
   input  logic signed [15:0] req_chan2,
   input  logic signed [15:0] req_chan3,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte
);

   crc_ctrl_type crc_ctrl;
   logic [7:0]   crc_byte;
   logic [15:0]  crc_value;

   // Byte sequencer and result register.
   sfcb_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_chan0      (req_chan0),
      .req_chan1      (req_chan1),
      .req_chan2      (req_chan2),
      .req_chan3      (req_chan3),
      .crc_value      (crc_value),
      .crc_ctrl       (crc_ctrl),
      .crc_byte       (crc_byte),
      .rsp_strobe     (rsp_strobe),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   // Running CRC over the data bytes as they are sent.
   sfcb_crc_unit u_crc_unit (
      .clock     (clock),
      .crc_ctrl  (crc_ctrl),
      .crc_byte  (crc_byte),
      .crc_value (crc_value)
   );

endmodule

// File: dv/tb_scope_frame_crc16_builder_top.sv
// Self-checking testbench for the telemetry framer: drives four-sample items and checks
// every frame byte, CRC-16/MODBUS included. Depends only on the framer top.
`timescale 1ns / 1ps

module tb_scope_frame_crc16_builder_top;

   // Frame layout and CRC parameters as the protocol defines them.
   localparam int unsigned FRAME_LEN = 10;
   localparam int unsigned DATA_LEN = 8;
   localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
   localparam logic [15:0] MODBUS_POLY = 16'hA001;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_chan0;
   logic signed [15:0] req_chan1;
   logic signed [15:0] req_chan2;
   logic signed [15:0] req_chan3;
   logic               rsp_strobe;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_last_byte;

   frame_byte_type pending_bytes[$];
   int unsigned error_count = 0;
   int unsigned frames_sent = 0;
   int unsigned bytes_checked = 0;
   int unsigned stall_cycles = 0;

   scope_frame_crc16_builder_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_chan0      (req_chan0),
      .req_chan1      (req_chan1),
      .req_chan2      (req_chan2),
      .req_chan3      (req_chan3),
      .rsp_strobe     (rsp_strobe),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   // Free-running clock with an 8 ns period.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // CRC over the 64 data bits, fed serially LSB first in frame order.
   function automatic logic [15:0] modbus_crc_of(input logic [63:0] data_bits);
      logic [15:0] acc;
      logic        feedback;
      acc = MODBUS_SEED;
      for (int i = 0; i < DATA_LEN * 8; i++) begin
         feedback = acc[0] ^ data_bits[i];
         acc = acc >> 1;
         if (feedback) begin
            acc = acc ^ MODBUS_POLY;
         end
      end
      return acc;
   endfunction

   // Works out the ten bytes of one frame and queues them in order.
   task automatic predict_frame(input logic [15:0] c0, input logic [15:0] c1,
                                input logic [15:0] c2, input logic [15:0] c3);
      logic [63:0] data_bits;
      logic [15:0] crc;
      frame_byte_type entry;
      data_bits = {c3, c2, c1, c0};
      crc = modbus_crc_of(data_bits);
      for (int k = 0; k < FRAME_LEN; k++) begin
         if (k < DATA_LEN) begin
            entry.value = data_bits[8*k +: 8];
         end else begin
            entry.value = crc[8*(k-DATA_LEN) +: 8];
         end
         entry.last = (k == FRAME_LEN - 1);
         pending_bytes.push_back(entry);
      end
   endtask

   // Offers one item from a falling edge and returns at the falling edge after acceptance.
   task automatic send_item(input logic [15:0] c0, input logic [15:0] c1,
                            input logic [15:0] c2, input logic [15:0] c3);
      start <= 1'b1;
      req_chan0 <= c0;
      req_chan1 <= c1;
      req_chan2 <= c2;
      req_chan3 <= c3;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      predict_frame(c0, c1, c2, c3);
      frames_sent++;
      @(negedge clock);
   endtask

   // Sender gap: start low, sample ports carry noise.
   task automatic idle_burst(input int unsigned cycles);
      start <= 1'b0;
      req_chan0 <= 16'($urandom);
      req_chan1 <= 16'($urandom);
      req_chan2 <= 16'($urandom);
      req_chan3 <= 16'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   // Random sample, weighted toward the corner patterns.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_item();
      send_item(pick_sample(), pick_sample(), pick_sample(), pick_sample());
   endtask

   // Corner patterns: zero, all ones, both signed extremes, single bits and mixed signs.
   task automatic test_sample_extremes();
      send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      idle_burst(3);
      send_item(16'h0001, 16'h0100, 16'h0001, 16'h0100);
      send_item(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
      send_item(16'hFFFE, 16'h0002, 16'hFF38, 16'h00C8);
      idle_burst(1);
      send_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_item(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00);
      send_item(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
   endtask

   // Byte order per channel: the first two items carry a distinct marker in each byte position.
   task automatic test_byte_order();
      send_item(16'h0201, 16'h0403, 16'h0605, 16'h0807);
      send_item(16'hF1F0, 16'hF3F2, 16'hF5F4, 16'hF7F6);
      idle_burst(13);
      send_item(16'h8001, 16'h8001, 16'h8001, 16'h8001);
   endtask

   // Random items in chunks that either stream or carry random gaps on the sender.
   task automatic test_random_with_gaps(input int unsigned items);
      int unsigned chunk_left;
      bit          gappy;
      chunk_left = 0;
      gappy = 1'b0;
      for (int unsigned n = 0; n < items; n++) begin
         if (chunk_left == 0) begin
            chunk_left = $urandom_range(10, 40);
            gappy = ($urandom_range(0, 3) != 0);
         end
         chunk_left--;
         if (gappy && $urandom_range(0, 2) == 0) begin
            idle_burst($urandom_range(1, 13));
         end
         send_random_item();
      end
   endtask

   // Frames back to back with start held high throughout.
   task automatic test_streaming(input int unsigned items);
      for (int unsigned n = 0; n < items; n++) begin
         send_random_item();
      end
   endtask

   // Each strobed byte is compared with the oldest expected byte.
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_strobe) begin
         if (pending_bytes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected byte: expected none, actual byte %h last %b",
                     $time, rsp_frame_byte, rsp_last_byte);
         end else begin
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_frame_byte !== want.value) begin
               error_count++;
               $display("%0t: frame_byte mismatch: expected %h, actual %h",
                        $time, want.value, rsp_frame_byte);
            end
            if (rsp_last_byte !== want.last) begin
               error_count++;
               $display("%0t: last_byte mismatch: expected %b, actual %b",
                        $time, want.last, rsp_last_byte);
            end
         end
      end
   end

   // Watchdog on cycles in which neither an item nor a byte is accepted.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired with %0d bytes outstanding", $time,
                  pending_bytes.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_chan0 = '0;
      req_chan1 = '0;
      req_chan2 = '0;
      req_chan3 = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_sample_extremes();
      test_byte_order();
      test_random_with_gaps(380);
      test_streaming(80);

      start <= 1'b0;
      while (pending_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d frames and checked %0d bytes: sample extremes, byte order,",
               frames_sent, bytes_checked);
      $display("random samples with sender gaps, and back-to-back streaming.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
